// ===== design/bcsh_pkg.sv =====
// Shared types, lookup tables and fixed-point helpers for the bitcrusher core.
package bcsh_pkg;

    // tanh on [0,2], step 1/16, Q0.23
    localparam logic [22:0] TANH_TAB [33] = '{
        23'd0,       23'd523606,  23'd1043149, 23'd1554686, 23'd2054530, 23'd2539316,
        23'd3006116, 23'd3452499, 23'd3876518, 23'd4276756, 23'd4652322, 23'd5002748,
        23'd5328016, 23'd5628479, 23'd5904793, 23'd6157842, 23'd6388714, 23'd6598638,
        23'd6788909, 23'd6960884, 23'd7115922, 23'd7255366, 23'd7380524, 23'd7492646,
        23'd7592932, 23'd7682497, 23'd7762364, 23'd7833517, 23'd7896834, 23'd7953114,
        23'd8003110, 23'd8047486, 23'd8086853
    };

    // 1/tanh(1+0.45r), Q2.22, over r in 1/16 steps
    localparam logic [22:0] INV_TAB [17] = '{
        23'd5507270, 23'd5424917, 23'd5348346, 23'd5277076, 23'd5210676, 23'd5148760,
        23'd5090973, 23'd5037001, 23'd4986553, 23'd4939371, 23'd4895212, 23'd4853860,
        23'd4815115, 23'd4778792, 23'd4744725, 23'd4712758, 23'd4682748
    };

    // 2^(j/16), Q1.15
    localparam logic [15:0] POW2_UP [16] = '{
        16'd32768, 16'd34219, 16'd35734, 16'd37316, 16'd38968, 16'd40693, 16'd42495,
        16'd44376, 16'd46341, 16'd48393, 16'd50535, 16'd52773, 16'd55109, 16'd57549,
        16'd60097, 16'd62757
    };

    // 2^(-j/16), Q1.17
    localparam logic [17:0] POW2_DN [16] = '{
        18'd131072, 18'd125515, 18'd120194, 18'd115098, 18'd110218, 18'd105545,
        18'd101071, 18'd96785,  18'd92682,  18'd88753,  18'd84990,  18'd81387,
        18'd77936,  18'd74632,  18'd71468,  18'd68438
    };

    localparam logic [31:0] SEED_RESET = 32'd1597463007;

    typedef struct packed {
        logic en;     // load accumulator
        logic accum;  // add product to accumulator instead of replacing
    } t_mac_op;

    typedef struct packed {
        logic        sat;
        logic [22:0] base;
        logic [19:0] d;
        logic [18:0] f;
    } t_tanh_lk;

    // rounding right shift, half away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input logic [6:0] s);
        logic [63:0] m;
        logic [63:0] half;
        m    = v[63] ? 64'(-v) : 64'(v);
        half = (s == 7'd0) ? 64'd0 : (64'd1 << (s - 7'd1));
        m    = (m + half) >> s;
        if (s == 7'd0) begin
            return v;
        end
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v < -64'sd8388608) begin
            return -24'sd8388608;
        end else if (v > 64'sd8388607) begin
            return 24'sd8388607;
        end
        return 24'(v);
    endfunction

    // segment fetch for tanh on a magnitude
    function automatic t_tanh_lk tanh_lookup(input logic [25:0] m);
        t_tanh_lk   lk;
        logic [5:0] i;
        i       = {1'b0, m[23:19]};
        lk.sat  = (m[25:24] != 2'b00);
        lk.base = lk.sat ? TANH_TAB[32] : TANH_TAB[i];
        lk.d    = 20'(TANH_TAB[i + 6'd1] - TANH_TAB[i]);
        lk.f    = m[18:0];
        return lk;
    endfunction

endpackage

// ===== design/bcsh_mac.sv =====
// Shared signed multiply-accumulate unit with registered accumulator.
module bcsh_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bcsh_pkg::t_mac_op    i_op,
    input  logic signed [35:0]   i_a,
    input  logic signed [25:0]   i_b,
    output logic signed [63:0]   o_acc
);
    import bcsh_pkg::*;

    logic signed [61:0] prod;
    logic signed [63:0] r_acc;

    assign prod  = i_a * i_b;
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_op.en) begin
            r_acc <= i_op.accum ? r_acc + 64'(prod) : 64'(prod);
        end
    end
endmodule

// ===== design/bcsh_isqrt.sv =====
// Iterative integer square root (floor), one root bit per pass.
module bcsh_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_val,
    output logic [16:0] o_root,
    output logic        o_done
);
    import bcsh_pkg::*;

    logic [32:0] r_v;
    logic [33:0] r_res;
    logic [32:0] r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] sum;

    assign sum    = r_res + {1'b0, r_bit};
    assign o_root = r_res[16:0];
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_v    <= i_val;
            r_res  <= '0;
            r_bit  <= 33'h1_0000_0000;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if ({1'b0, r_v} >= sum) begin
                r_v   <= r_v - sum[32:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd16) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule

// ===== design/bitcrusher_sample_hold_slew_core.sv =====
// Bitcrusher core: soft clip, quantize, per-channel sample-and-hold, slew, fizz, mix.
//
// One sample is accepted when the core is idle. It then passes through 23
// sequencer steps and a wait on the bit-pair square root, which derives bit
// depth from roughness in 17 passes. Of the 23 steps, 22 each issue one
// product to a single shared 36x26 multiply-accumulate unit, and the last
// one rounds and saturates the output. The core is ready again as soon as
// the result is loaded, and it does not take a new sample before the last
// one is through. The result sits in an output register, so the next sample
// may be accepted while it waits; apart from the square-root wait, the
// sequencer pauses only in its final step, if a prior result is still
// untaken. Roughness r = min(1, crush*(0.88+0.18*env)) drives every stage:
// tanh soft clip with drive compensation, quantization to 2^(16-9.75*sqrt(r))
// steps, a hold of 1+floor(18 r^2) samples blended by r, one-pole slew,
// LCG noise scaled by r^2, a tanh saturator and a dry/wet mix. Hold and slew
// state is kept per channel; a channel index beyond the last channel uses
// the last one. Samples are converted to and from an internal Q1.23 format.
module bitcrusher_sample_hold_slew_core #(
    parameter int NUM_CHANNELS = 2,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [15:0]                   i_crush_amount,
    input  logic [15:0]                   i_envelope_level,
    input  logic                          i_channel_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);
    import bcsh_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DOWN = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
    localparam int UP   = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
    localparam logic signed [63:0] OUT_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    // sequencer steps
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_F    = 5'd1;
    localparam logic [4:0] S_R    = 5'd2;
    localparam logic [4:0] S_RS   = 5'd3;
    localparam logic [4:0] S_R2   = 5'd4;
    localparam logic [4:0] S_SQ   = 5'd5;
    localparam logic [4:0] S_BQ   = 5'd6;
    localparam logic [4:0] S_TA   = 5'd7;
    localparam logic [4:0] S_TB   = 5'd8;
    localparam logic [4:0] S_TC   = 5'd9;
    localparam logic [4:0] S_PU   = 5'd10;
    localparam logic [4:0] S_PD   = 5'd11;
    localparam logic [4:0] S_HQ   = 5'd12;
    localparam logic [4:0] S_QB   = 5'd13;
    localparam logic [4:0] S_CO   = 5'd14;
    localparam logic [4:0] S_SL   = 5'd15;
    localparam logic [4:0] S_SD   = 5'd16;
    localparam logic [4:0] S_FZ   = 5'd17;
    localparam logic [4:0] S_FZ2  = 5'd18;
    localparam logic [4:0] S_G    = 5'd19;
    localparam logic [4:0] S_TD   = 5'd20;
    localparam logic [4:0] S_TE   = 5'd21;
    localparam logic [4:0] S_MX   = 5'd22;
    localparam logic [4:0] S_MY   = 5'd23;
    localparam logic [4:0] S_OUT  = 5'd24;

    // control
    logic [4:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic [31:0] r_seed, n_seed;

    // per-channel state
    logic [4:0]         r_hold [NUM_CHANNELS];
    logic signed [23:0] r_held [NUM_CHANNELS];
    logic signed [23:0] r_slew [NUM_CHANNELS];
    logic               hold_we;
    logic [4:0]         hold_wd;
    logic signed [23:0] held_wd;
    logic               slew_we;
    logic signed [23:0] slew_wd;

    // working registers
    logic signed [23:0] r_x, n_x;
    logic [15:0]        r_c, n_c;
    logic [15:0]        r_e, n_e;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic [16:0]        r_r, n_r;
    logic [16:0]        r_r2, n_r2;
    logic [4:0]         r_maxhold, n_maxhold;
    logic [4:0]         r_ib, n_ib;
    logic [3:0]         r_j, n_j;
    t_tanh_lk           r_lk, n_lk;
    logic signed [23:0] r_t, n_t;
    logic               r_inv_sat, n_inv_sat;
    logic [22:0]        r_inv_base, n_inv_base;
    logic signed [23:0] r_q, n_q;
    logic signed [23:0] r_qb, n_qb;
    logic signed [17:0] r_fizz, n_fizz;
    logic signed [25:0] r_a, n_a;
    logic signed [23:0] r_deg, n_deg;
    logic [16:0]        r_mix, n_mix;
    logic signed [SAMPLE_BITS-1:0] r_out, n_out;

    // shared units
    t_mac_op            mac_op;
    logic signed [35:0] mac_a;
    logic signed [25:0] mac_b;
    logic signed [63:0] acc;
    logic               sq_start;
    logic [16:0]        sq_root;
    logic               sq_done;

    // step temporaries
    logic signed [63:0] c_sh;
    logic [16:0]        c_u17;
    logic [8:0]         c_bq;
    logic [23:0]        c_xm;
    logic [25:0]        c_am;
    logic [22:0]        c_mag;
    logic [4:0]         c_ii;
    logic signed [23:0] c_sv;
    logic signed [24:0] c_diff;
    logic signed [19:0] c_n;
    logic signed [24:0] c_bip;
    logic signed [23:0] c_y;
    logic signed [63:0] c_yo;
    logic [4:0]         c_hc;
    logic signed [23:0] c_hsel;

    bcsh_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    bcsh_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   ({r_r, 16'b0}),
        .o_root  (sq_root),
        .o_done  (sq_done)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_sample_out = r_out;

    assign c_sv = r_slew[r_ch];

    always_comb begin
        n_state    = r_state;
        n_ovalid   = r_ovalid & ~i_ready;
        n_seed     = r_seed;
        n_x        = r_x;
        n_c        = r_c;
        n_e        = r_e;
        n_ch       = r_ch;
        n_r        = r_r;
        n_r2       = r_r2;
        n_maxhold  = r_maxhold;
        n_ib       = r_ib;
        n_j        = r_j;
        n_lk       = r_lk;
        n_t        = r_t;
        n_inv_sat  = r_inv_sat;
        n_inv_base = r_inv_base;
        n_q        = r_q;
        n_qb       = r_qb;
        n_fizz     = r_fizz;
        n_a        = r_a;
        n_deg      = r_deg;
        n_mix      = r_mix;
        n_out      = r_out;
        mac_op     = '0;
        mac_a      = '0;
        mac_b      = '0;
        sq_start   = 1'b0;
        hold_we    = 1'b0;
        hold_wd    = '0;
        held_wd    = '0;
        slew_we    = 1'b0;
        slew_wd    = '0;
        c_sh       = '0;
        c_u17      = '0;
        c_bq       = '0;
        c_xm       = '0;
        c_am       = '0;
        c_mag      = '0;
        c_ii       = '0;
        c_diff     = '0;
        c_n        = '0;
        c_bip      = '0;
        c_y        = '0;
        c_yo       = '0;
        c_hc       = '0;
        c_hsel     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_x = sat24(rshr(64'(i_sample_in), 7'(DOWN)) <<< UP);
                    n_c = i_crush_amount;
                    n_e = i_envelope_level;
                    n_ch = (32'(i_channel_index) >= NUM_CHANNELS) ?
                           CH_W'(NUM_CHANNELS - 1) : CH_W'(i_channel_index);
                    n_state = S_F;
                end
            end
            S_F: begin
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_e);
                mac_b   = 26'sd11796;
                n_state = S_R;
            end
            S_R: begin
                c_u17   = 17'(64'sd57672 + rshr(acc, 7'd16));
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_c);
                mac_b   = 26'(c_u17);
                n_state = S_RS;
            end
            S_RS: begin
                c_sh    = rshr(acc, 7'd16);
                n_r     = (c_sh > 64'sd65536) ? 17'd65536 : 17'(c_sh);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(n_r);
                mac_b   = 26'(n_r);
                n_state = S_R2;
            end
            S_R2: begin
                n_r2     = 17'(rshr(acc, 7'd16));
                sq_start = 1'b1;
                mac_op   = '{en: 1'b1, accum: 1'b0};
                mac_a    = 36'(n_r2);
                mac_b    = 26'sd18;
                n_state  = S_SQ;
            end
            S_SQ: begin
                if (sq_done) begin
                    n_state = S_BQ;
                end
            end
            S_BQ: begin
                n_maxhold = 5'(64'sd1 + (acc >>> 16));
                mac_op    = '{en: 1'b1, accum: 1'b0};
                mac_a     = 36'(sq_root);
                mac_b     = 26'sd39;
                n_state   = S_TA;
            end
            S_TA: begin
                c_bq    = 9'((64'sd1048576 - rshr(acc, 7'd2)) >>> 12);
                n_ib    = c_bq[8:4];
                n_j     = c_bq[3:0];
                c_xm    = r_x[23] ? 24'(-r_x) : 24'(r_x);
                n_lk    = tanh_lookup({2'b00, c_xm});
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(n_lk.d);
                mac_b   = 26'(n_lk.f);
                n_state = S_TB;
            end
            S_TB: begin
                c_mag = r_lk.sat ? r_lk.base :
                        r_lk.base + 23'((acc + 64'sd262144) >>> 19);
                n_t   = r_x[23] ? -24'(c_mag) : 24'(c_mag);
                c_ii  = r_r[16:12];
                n_inv_sat  = (c_ii >= 5'd16);
                n_inv_base = n_inv_sat ? INV_TAB[16] : INV_TAB[{1'b0, c_ii[3:0]}];
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(23'(INV_TAB[{1'b0, c_ii[3:0]}] -
                               INV_TAB[{1'b0, c_ii[3:0]} + 5'd1]));
                mac_b   = 26'(r_r[11:0]);
                n_state = S_TC;
            end
            S_TC: begin
                c_mag   = r_inv_sat ? r_inv_base :
                          r_inv_base - 23'((acc + 64'sd2048) >>> 12);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_t);
                mac_b   = 26'(c_mag);
                n_state = S_PU;
            end
            S_PU: begin
                n_q     = sat24(rshr(acc, 7'd22));   // conditioned sample
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(n_q);
                mac_b   = 26'(POW2_UP[r_j]);
                n_state = S_PD;
            end
            S_PD: begin
                c_n     = 20'(rshr(acc, 7'd38 - 7'(r_ib)));
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(c_n);
                mac_b   = 26'(POW2_DN[r_j]);
                n_state = S_HQ;
            end
            S_HQ: begin
                n_q     = sat24(rshr(acc, 7'(r_ib) - 7'd6));
                c_hc    = r_hold[r_ch];
                c_hsel  = (c_hc == 5'd0) ? n_q : r_held[r_ch];
                hold_we = 1'b1;
                held_wd = c_hsel;
                hold_wd = ((c_hc == 5'd0) ? r_maxhold : c_hc) - 5'd1;
                c_diff  = 25'(c_hsel) - 25'(n_q);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(c_diff);
                mac_b   = 26'(r_r);
                n_state = S_QB;
            end
            S_QB: begin
                n_qb    = sat24(64'(r_q) + rshr(acc, 7'd16));
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_r);
                mac_b   = 26'sd28836;
                n_state = S_CO;
            end
            S_CO: begin
                c_u17   = 17'(64'sd40632 - rshr(acc, 7'd16));   // slew coefficient
                c_diff  = 25'(r_qb) - 25'(c_sv);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(c_diff);
                mac_b   = 26'(c_u17);
                n_state = S_SL;
            end
            S_SL: begin
                slew_we = 1'b1;
                slew_wd = sat24(64'(c_sv) + rshr(acc, 7'd16));
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_seed);
                mac_b   = 26'sd1664525;
                n_state = S_SD;
            end
            S_SD: begin
                n_seed  = acc[31:0] + 32'd1013904223;
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_r2);
                mac_b   = 26'sd100663;
                n_state = S_FZ;
            end
            S_FZ: begin
                c_bip   = $signed({1'b0, r_seed[31:8]}) - 25'sd8388608;
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(acc[33:0]);
                mac_b   = 26'(c_bip);
                n_state = S_FZ2;
            end
            S_FZ2: begin
                n_fizz  = 18'(rshr(acc, 7'd40));
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_r);
                mac_b   = 26'sd22938;
                n_state = S_G;
            end
            S_G: begin
                c_u17   = 17'(64'sd65536 + rshr(acc, 7'd16));   // saturator drive
                c_diff  = 25'(c_sv) + 25'(r_fizz);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(c_diff);
                mac_b   = 26'(c_u17);
                n_state = S_TD;
            end
            S_TD: begin
                n_a     = 26'(rshr(acc, 7'd16));
                c_am    = n_a[25] ? 26'(-n_a) : 26'(n_a);
                n_lk    = tanh_lookup(c_am);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(n_lk.d);
                mac_b   = 26'(n_lk.f);
                n_state = S_TE;
            end
            S_TE: begin
                c_mag   = r_lk.sat ? r_lk.base :
                          r_lk.base + 23'((acc + 64'sd262144) >>> 19);
                n_deg   = r_a[25] ? -24'(c_mag) : 24'(c_mag);
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_r);
                mac_b   = 26'sd43254;
                n_state = S_MX;
            end
            S_MX: begin
                n_mix   = 17'(64'sd11796 + rshr(acc, 7'd16));
                mac_op  = '{en: 1'b1, accum: 1'b0};
                mac_a   = 36'(r_x);
                mac_b   = 26'(17'(17'd65536 - n_mix));
                n_state = S_MY;
            end
            S_MY: begin
                mac_op  = '{en: 1'b1, accum: 1'b1};
                mac_a   = 36'(r_deg);
                mac_b   = 26'(r_mix);
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait here only if the previous result is still untaken
                if (!r_ovalid || i_ready) begin
                    c_y  = sat24(rshr(acc, 7'd16));
                    c_yo = rshr(64'(c_y) <<< DOWN, 7'(UP));
                    if (c_yo < OUT_LO) begin
                        c_yo = OUT_LO;
                    end else if (c_yo > OUT_HI) begin
                        c_yo = OUT_HI;
                    end
                    n_out    = SAMPLE_BITS'(c_yo);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_seed   <= SEED_RESET;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_hold[k] <= '0;
                r_held[k] <= '0;
                r_slew[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_seed   <= n_seed;
            if (hold_we) begin
                r_hold[r_ch] <= hold_wd;
                r_held[r_ch] <= held_wd;
            end
            if (slew_we) begin
                r_slew[r_ch] <= slew_wd;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_c        <= n_c;
        r_e        <= n_e;
        r_ch       <= n_ch;
        r_r        <= n_r;
        r_r2       <= n_r2;
        r_maxhold  <= n_maxhold;
        r_ib       <= n_ib;
        r_j        <= n_j;
        r_lk       <= n_lk;
        r_t        <= n_t;
        r_inv_sat  <= n_inv_sat;
        r_inv_base <= n_inv_base;
        r_q        <= n_q;
        r_qb       <= n_qb;
        r_fizz     <= n_fizz;
        r_a        <= n_a;
        r_deg      <= n_deg;
        r_mix      <= n_mix;
        r_out      <= n_out;
    end
endmodule

// ===== tb/tb_bitcrusher_sample_hold_slew_core.sv =====
// Self-checking testbench for the bitcrusher sample-hold-slew core.
`timescale 1ns / 1ps

module tb_bitcrusher_sample_hold_slew_core;
    import bcsh_pkg::*;

    localparam int  NCH       = 2;
    localparam int  SBITS     = 24;
    localparam int  N_RANDOM  = 1130;
    localparam int  MAX_CYCLE = 1000000;
    localparam int  TAIL_WAIT = 120;   // idle wait after the queues drain
    localparam int  PHASE_LEN = 380;   // transfers per idling phase

    typedef struct {
        logic signed [SBITS-1:0] smp;
        logic [15:0]             crush;
        logic [15:0]             env;
        logic                    chan;
    } t_sample_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    i_valid          = 1'b0;
    logic signed [SBITS-1:0] i_sample_in      = '0;
    logic [15:0]             i_crush_amount   = '0;
    logic [15:0]             i_envelope_level = '0;
    logic                    i_channel_index  = 1'b0;
    logic                    i_ready          = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic signed [SBITS-1:0] o_sample_out;

    bitcrusher_sample_hold_slew_core #(
        .NUM_CHANNELS(NCH),
        .SAMPLE_BITS (SBITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_in     (i_sample_in),
        .i_crush_amount  (i_crush_amount),
        .i_envelope_level(i_envelope_level),
        .i_channel_index (i_channel_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_out    (o_sample_out)
    );

    always #5 i_clk = ~i_clk;

    // stimulus waiting to be offered, and crushed samples awaiting the output
    t_sample_item     pending_q[$];
    logic [SBITS-1:0] crushed_q[$];

    int  n_fail     = 0;
    int  n_sent     = 0;
    int  n_received = 0;
    int  cycle      = 0;

    // predictor copy of the per-channel state
    int      pr_hold   [NCH];
    longint  pr_held   [NCH];
    longint  pr_slew   [NCH];
    logic [31:0] pr_seed;

    // ---------------------------------------------------------------
    // Fixed-point helpers of the predictor
    // ---------------------------------------------------------------
    // shift right with rounding half away from zero
    function automatic longint rnd_shift(input longint v, input int s);
        longint m;
        if (s == 0) return v;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp_q23(input longint v);
        if (v < -8388608) return -8388608;
        if (v > 8388607) return 8388607;
        return v;
    endfunction

    // table tanh with interpolation, saturating at |a| >= 2
    function automatic longint soft_tanh(input longint a);
        longint m, y, d, fr;
        int     i;
        m = (a < 0) ? -a : a;
        if (m >= (longint'(1) << 24)) begin
            y = longint'(TANH_TAB[32]);
        end else begin
            i  = int'(m >>> 19);
            fr = m & 64'h7FFFF;
            d  = longint'(TANH_TAB[i + 1]) - longint'(TANH_TAB[i]);
            y  = longint'(TANH_TAB[i]) + ((d * fr + (longint'(1) << 18)) >>> 19);
        end
        return (a < 0) ? -y : y;
    endfunction

    // drive compensation 1/tanh(1+0.45r), Q2.22
    function automatic longint drive_comp(input longint r);
        int     i;
        longint d, fr;
        i = int'(r >>> 12);
        if (i >= 16) return longint'(INV_TAB[16]);
        fr = r & 64'hFFF;
        d  = longint'(INV_TAB[i]) - longint'(INV_TAB[i + 1]);
        return longint'(INV_TAB[i]) - ((d * fr + 2048) >>> 12);
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint res, b;
        res = 0;
        b   = longint'(1) << 32;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    // Crush one sample and advance the predictor state.
    function automatic logic [SBITS-1:0] crush_sample(input t_sample_item it);
        longint x, f, r, sr, cnd, bq, n, q, r2, qb, coef, bip, fizz, g, deg, mix, y;
        int     ch, ib, j, maxhold;
        x  = longint'(it.smp);
        ch = int'(it.chan);
        if (ch >= NCH) ch = NCH - 1;

        f = 57672 + rnd_shift(11796 * longint'(it.env), 16);
        r = rnd_shift(longint'(it.crush) * f, 16);
        if (r > 65536) r = 65536;
        sr = floor_sqrt(r << 16);

        cnd = clamp_q23(rnd_shift(soft_tanh(x) * drive_comp(r), 22));

        // bit depth in 1/16 units; ib ranges 6..16
        bq = (1048576 - rnd_shift(39 * sr, 2)) >>> 12;
        ib = int'(bq >>> 4);
        j  = int'(bq & 15);
        n  = rnd_shift(cnd * longint'(POW2_UP[j]), 38 - ib);
        q  = clamp_q23(rnd_shift(n * longint'(POW2_DN[j]), ib - 6));

        r2      = rnd_shift(r * r, 16);
        maxhold = 1 + int'((r2 * 18) >>> 16);
        if (pr_hold[ch] == 0) begin
            pr_held[ch] = q;
            pr_hold[ch] = maxhold;
        end
        pr_hold[ch] = pr_hold[ch] - 1;
        qb = clamp_q23(q + rnd_shift((pr_held[ch] - q) * r, 16));

        coef        = 40632 - rnd_shift(28836 * r, 16);
        pr_slew[ch] = clamp_q23(pr_slew[ch] + rnd_shift(coef * (qb - pr_slew[ch]), 16));

        pr_seed = pr_seed * 32'd1664525 + 32'd1013904223;
        bip     = longint'((pr_seed >> 8) & 32'hFFFFFF) - 8388608;
        fizz    = rnd_shift(bip * r2 * 100663, 40);

        g   = 65536 + rnd_shift(22938 * r, 16);
        deg = soft_tanh(rnd_shift((pr_slew[ch] + fizz) * g, 16));

        mix = 11796 + rnd_shift(43254 * r, 16);
        y   = clamp_q23(rnd_shift(x * (65536 - mix) + deg * mix, 16));
        return y[SBITS-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued items, idling by phase
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        int          idle_pct;
        logic        take_next;
        logic        done_xfer;
        logic [31:0] roll;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            done_xfer = i_valid && o_ready;
            if (done_xfer) begin
                crushed_q.push_back(crush_sample('{i_sample_in, i_crush_amount,
                                                   i_envelope_level, i_channel_index}));
                n_sent++;
            end
            // phase 0: sender idles 28%, phase 1: 48%, then never
            if (n_sent < PHASE_LEN)          idle_pct = 28;
            else if (n_sent < 2 * PHASE_LEN) idle_pct = 48;
            else                             idle_pct = 0;
            roll = $urandom_range(99);
            if (!i_valid || done_xfer) begin
                take_next = (pending_q.size() != 0) && (roll >= idle_pct);
                if (take_next) begin
                    t_sample_item it;
                    it = pending_q.pop_front();
                    i_sample_in      <= it.smp;
                    i_crush_amount   <= it.crush;
                    i_envelope_level <= it.env;
                    i_channel_index  <= it.chan;
                    i_valid          <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks results and drives ready, with one long hold-off
    // ---------------------------------------------------------------
    int hold_off     = 0;
    bit hold_off_hit = 0;

    always @(posedge i_clk) begin
        int               idle_pct;
        logic [SBITS-1:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_received++;
                if (crushed_q.size() == 0) begin
                    $error("unexpected transfer: sample_out actual %0d",
                           $signed(o_sample_out));
                    n_fail++;
                end else begin
                    want = crushed_q.pop_front();
                    if (o_sample_out !== want) begin
                        $error("sample_out mismatch: expected %0d actual %0d",
                               $signed(want), $signed(o_sample_out));
                        n_fail++;
                    end
                end
            end
            // receiver idles 48%, then 28%, then never
            if (n_received < PHASE_LEN)          idle_pct = 48;
            else if (n_received < 2 * PHASE_LEN) idle_pct = 28;
            else                                 idle_pct = 0;
            // long stall so the core fills up and holds off its input
            if (!hold_off_hit && n_received == 2 * PHASE_LEN + 20) begin
                hold_off_hit = 1;
                hold_off     = 400;
            end
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle++;
        if (cycle > MAX_CYCLE) begin
            $display("tb_bitcrusher_sample_hold_slew_core NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] pick_level();
        case ($urandom_range(4))
            0:       return 16'(0);
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(8000));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [SBITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return {1'b1, {(SBITS-1){1'b0}}};
            1:       return {1'b0, {(SBITS-1){1'b1}}};
            2:       return SBITS'($signed($urandom_range(2000)) - 1000);
            default: return SBITS'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        t_sample_item it;
        int           run_len;
        logic         run_chan;
        int           k;
        for (k = 0; k < NCH; k++) begin
            pr_hold[k] = 0;
            pr_held[k] = 0;
            pr_slew[k] = 0;
        end
        pr_seed = SEED_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, zero roughness, saturated roughness
        // and a held run on one channel
        pending_q.push_back('{24'sd0,        16'h0000, 16'h0000, 1'b0});
        pending_q.push_back('{24'sh7FFFFF,   16'h0000, 16'h0000, 1'b0});
        pending_q.push_back('{-24'sh800000,  16'h0000, 16'h0000, 1'b1});
        pending_q.push_back('{24'sh7FFFFF,   16'hFFFF, 16'hFFFF, 1'b0});
        pending_q.push_back('{-24'sh800000,  16'hFFFF, 16'hFFFF, 1'b1});
        pending_q.push_back('{24'sh400000,   16'hFFFF, 16'h0000, 1'b0});
        pending_q.push_back('{-24'sh400000,  16'h8000, 16'hFFFF, 1'b1});
        pending_q.push_back('{24'sd1,        16'h0001, 16'h0001, 1'b0});
        pending_q.push_back('{-24'sd1,       16'h1000, 16'h8000, 1'b1});
        for (k = 0; k < 12; k++) begin
            pending_q.push_back('{SBITS'($urandom()), 16'hFFFF, 16'hFFFF, 1'b0});
        end
        pending_q.push_back('{24'sh123456,   16'hE000, 16'h4000, 1'b1});
        pending_q.push_back('{-24'sh0ABCDE,  16'h7FFF, 16'h7FFF, 1'b0});

        // random: runs on one channel so hold counters cycle through
        k = 0;
        while (k < N_RANDOM) begin
            run_len  = $urandom_range(30, 1);
            run_chan = 1'($urandom());
            it.crush = pick_level();
            it.env   = pick_level();
            repeat (run_len) begin
                if ($urandom_range(3) == 0) begin
                    it.crush = pick_level();
                    it.env   = pick_level();
                end
                it.smp  = pick_sample();
                it.chan = ($urandom_range(7) == 0) ? ~run_chan : run_chan;
                pending_q.push_back(it);
                k++;
            end
        end

        wait (pending_q.size() == 0 && !i_valid && crushed_q.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (crushed_q.size() != 0) begin
            $error("%0d crushed samples never arrived", crushed_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("tb_bitcrusher_sample_hold_slew_core OK");
        end else begin
            $display("tb_bitcrusher_sample_hold_slew_core NOT OK");
        end
        $finish;
    end

endmodule
